### hdl/trs_hierarchy_pose_compose_macros.svh
// Assertion macros shared by the pose composer checker.
`ifndef TRS_HIERARCHY_POSE_COMPOSE_MACROS_SVH
`define TRS_HIERARCHY_POSE_COMPOSE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TPC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TPC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/tpc_pkg.sv
// Package: widths, constants, micro-op program and control structs of the pose composer.
package tpc_pkg;

	localparam int POS_W = 48;
	localparam int Q_W = 32;
	localparam int S_W = 32;
	localparam int ACC_W = 64;
	localparam int MAG_W = 62;
	localparam int PROD_W = 94;
	localparam int IN_TDATA_W = 368;
	localparam int OUT_TDATA_W = 272;
	localparam int MAX_CHAIN_DEPTH_DEF = 512;
	localparam int NUM_UOPS = 43;
	localparam int UPC_W = 6;

	localparam logic signed [Q_W-1:0] Q_ONE = 32'sh4000_0000;
	localparam logic signed [POS_W-1:0] POS_LIMIT = 48'sd65536000000;

	// Operand A sources
	typedef enum logic [4:0] {
		A_POS0, A_POS1, A_POS2,
		A_P0, A_P1, A_P2,
		A_UV0, A_UV1, A_UV2,
		A_UUV0, A_UUV1, A_UUV2,
		A_T0, A_T1, A_T2,
		A_QW, A_QX, A_QY, A_QZ
	} src_a_t;

	// Operand B sources
	typedef enum logic [3:0] {
		B_S0, B_S1, B_S2,
		B_QW, B_QX, B_QY, B_QZ,
		B_RW, B_RX, B_RY, B_RZ,
		B_ONE
	} src_b_t;

	// Accumulator destinations
	typedef enum logic [3:0] {
		D_P0, D_P1, D_P2,
		D_UV0, D_UV1, D_UV2,
		D_UUV0, D_UUV1, D_UUV2,
		D_NR0, D_NR1, D_NR2, D_NR3
	} dst_t;

	typedef struct packed {
		src_a_t a;
		src_b_t b;
		logic   sh16;  // drop 16 fraction bits, else 30
		logic   sub;   // subtract the product from the accumulator
		dst_t   dst;
		logic   clr;   // start from zero instead of the destination
	} uop_t;

	typedef struct packed {
		logic             load;
		logic             seed;
		logic             start;
		logic             issue;
		logic [UPC_W-1:0] upc;
		logic             commit;
		logic             emit;
		logic             chain_err;
	} tpc_cmd_t;

	typedef struct packed {
		logic first;
		logic last;
		logic busy;
		logic bad;
	} tpc_stat_t;

	function automatic uop_t mk(input src_a_t a, input src_b_t b, input logic sh16,
			input logic sub, input dst_t dst, input logic clr);
		uop_t u;
		u.a = a;
		u.b = b;
		u.sh16 = sh16;
		u.sub = sub;
		u.dst = dst;
		u.clr = clr;
		return u;
	endfunction

	// One record's work: scale, rotation product, two cross products, final sums.
	function automatic uop_t uop_rom(input logic [UPC_W-1:0] idx);
		uop_t u;
		unique case (idx)
			6'd0:  u = mk(A_POS0, B_S0, 1'b1, 1'b0, D_P0, 1'b1);
			6'd1:  u = mk(A_POS1, B_S1, 1'b1, 1'b0, D_P1, 1'b1);
			6'd2:  u = mk(A_POS2, B_S2, 1'b1, 1'b0, D_P2, 1'b1);
			6'd3:  u = mk(A_QW, B_RW, 1'b0, 1'b0, D_NR0, 1'b1);
			6'd4:  u = mk(A_QX, B_RX, 1'b0, 1'b1, D_NR0, 1'b0);
			6'd5:  u = mk(A_QY, B_RY, 1'b0, 1'b1, D_NR0, 1'b0);
			6'd6:  u = mk(A_QZ, B_RZ, 1'b0, 1'b1, D_NR0, 1'b0);
			6'd7:  u = mk(A_QW, B_RX, 1'b0, 1'b0, D_NR1, 1'b1);
			6'd8:  u = mk(A_QX, B_RW, 1'b0, 1'b0, D_NR1, 1'b0);
			6'd9:  u = mk(A_QY, B_RZ, 1'b0, 1'b0, D_NR1, 1'b0);
			6'd10: u = mk(A_QZ, B_RY, 1'b0, 1'b1, D_NR1, 1'b0);
			6'd11: u = mk(A_P2, B_QY, 1'b0, 1'b0, D_UV0, 1'b1);
			6'd12: u = mk(A_P1, B_QZ, 1'b0, 1'b1, D_UV0, 1'b0);
			6'd13: u = mk(A_P0, B_QZ, 1'b0, 1'b0, D_UV1, 1'b1);
			6'd14: u = mk(A_P2, B_QX, 1'b0, 1'b1, D_UV1, 1'b0);
			6'd15: u = mk(A_P1, B_QX, 1'b0, 1'b0, D_UV2, 1'b1);
			6'd16: u = mk(A_P0, B_QY, 1'b0, 1'b1, D_UV2, 1'b0);
			6'd17: u = mk(A_QW, B_RY, 1'b0, 1'b0, D_NR2, 1'b1);
			6'd18: u = mk(A_QX, B_RZ, 1'b0, 1'b1, D_NR2, 1'b0);
			6'd19: u = mk(A_QY, B_RW, 1'b0, 1'b0, D_NR2, 1'b0);
			6'd20: u = mk(A_QZ, B_RX, 1'b0, 1'b0, D_NR2, 1'b0);
			6'd21: u = mk(A_QW, B_RZ, 1'b0, 1'b0, D_NR3, 1'b1);
			6'd22: u = mk(A_QX, B_RY, 1'b0, 1'b0, D_NR3, 1'b0);
			6'd23: u = mk(A_QY, B_RX, 1'b0, 1'b1, D_NR3, 1'b0);
			6'd24: u = mk(A_QZ, B_RW, 1'b0, 1'b0, D_NR3, 1'b0);
			6'd25: u = mk(A_UV2, B_QY, 1'b0, 1'b0, D_UUV0, 1'b1);
			6'd26: u = mk(A_UV1, B_QZ, 1'b0, 1'b1, D_UUV0, 1'b0);
			6'd27: u = mk(A_UV0, B_QZ, 1'b0, 1'b0, D_UUV1, 1'b1);
			6'd28: u = mk(A_UV2, B_QX, 1'b0, 1'b1, D_UUV1, 1'b0);
			6'd29: u = mk(A_UV1, B_QX, 1'b0, 1'b0, D_UUV2, 1'b1);
			6'd30: u = mk(A_UV0, B_QY, 1'b0, 1'b1, D_UUV2, 1'b0);
			6'd31: u = mk(A_UV0, B_QW, 1'b0, 1'b0, D_UUV0, 1'b0);
			6'd32: u = mk(A_UV1, B_QW, 1'b0, 1'b0, D_UUV1, 1'b0);
			6'd33: u = mk(A_UV2, B_QW, 1'b0, 1'b0, D_UUV2, 1'b0);
			6'd34: u = mk(A_UUV0, B_ONE, 1'b0, 1'b0, D_UUV0, 1'b0);
			6'd35: u = mk(A_UUV1, B_ONE, 1'b0, 1'b0, D_UUV1, 1'b0);
			6'd36: u = mk(A_UUV2, B_ONE, 1'b0, 1'b0, D_UUV2, 1'b0);
			6'd37: u = mk(A_P0, B_ONE, 1'b0, 1'b0, D_UUV0, 1'b0);
			6'd38: u = mk(A_P1, B_ONE, 1'b0, 1'b0, D_UUV1, 1'b0);
			6'd39: u = mk(A_P2, B_ONE, 1'b0, 1'b0, D_UUV2, 1'b0);
			6'd40: u = mk(A_T0, B_ONE, 1'b0, 1'b0, D_UUV0, 1'b0);
			6'd41: u = mk(A_T1, B_ONE, 1'b0, 1'b0, D_UUV1, 1'b0);
			6'd42: u = mk(A_T2, B_ONE, 1'b0, 1'b0, D_UUV2, 1'b0);
			default: u = mk(A_T0, B_ONE, 1'b0, 1'b0, D_UUV0, 1'b1);
		endcase
		return u;
	endfunction

endpackage

### hdl/trs_hierarchy_pose_compose.sv
// Top level: world pose composer for a chain of translation-rotation-scale records.
// A first record or one skipped after a chain error goes from decide back to idle, or
// to emit on a last record. A composing record issues 43 micro-ops into one shared
// 32x32 multiplier, then the pipeline drains and a commit state follows.
// A result sits in the output register; the next record is taken while it waits.
// Reset clears the pose to zero position, identity rotation, and the chain state.
module trs_hierarchy_pose_compose #(
	parameter int MAX_CHAIN_DEPTH = tpc_pkg::MAX_CHAIN_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [tpc_pkg::IN_TDATA_W-1:0]  s_tdata,  // trans_x,y,z, quat_w,x,y,z, scale_x,y,z
	input  logic                            s_tuser,  // first_record
	input  logic                            s_tlast,  // last_record
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tpc_pkg::OUT_TDATA_W-1:0] m_tdata,  // world_x,y,z, rot_w,x,y,z
	output logic                            m_tuser   // pose_ok
);
	import tpc_pkg::*;

	tpc_cmd_t  cmd;
	tpc_stat_t stat;

	tpc_ctrl #(
		.MAX_CHAIN_DEPTH(MAX_CHAIN_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	tpc_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.cmd     (cmd),
		.stat    (stat)
	);

endmodule

### hdl/tpc_ctrl.sv
// Controller: record sequencing, micro-op issue, chain bookkeeping and output valid.
module tpc_ctrl #(
	parameter int MAX_CHAIN_DEPTH = tpc_pkg::MAX_CHAIN_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output tpc_pkg::tpc_cmd_t  cmd,
	input  tpc_pkg::tpc_stat_t stat
);
	import tpc_pkg::*;

	localparam int CNT_W = (MAX_CHAIN_DEPTH > 1) ? $clog2(MAX_CHAIN_DEPTH) : 1;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECIDE = 6'b000010,
		S_ISSUE  = 6'b000100,
		S_DRAIN  = 6'b001000,
		S_COMMIT = 6'b010000,
		S_EMIT   = 6'b100000
	} state_t;

	state_t           state_q, state_d;
	logic [UPC_W-1:0] upc_q;
	logic             phase_q;
	logic             chain_err_q;
	logic [CNT_W-1:0] chain_cnt_q;
	logic             out_valid_q;
	logic [CNT_W:0]   idx;
	logic             too_long;
	logic             emit_go;

	assign idx = (CNT_W+1)'(chain_cnt_q) + (CNT_W+1)'(1);
	assign too_long = (idx >= (CNT_W+1)'(MAX_CHAIN_DEPTH));
	assign emit_go = (state_q == S_EMIT) && (!out_valid_q || m_tready);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	// Commands to the datapath
	always_comb begin
		cmd = '0;
		cmd.load = (state_q == S_IDLE) && s_tvalid;
		cmd.seed = (state_q == S_DECIDE) && stat.first;
		cmd.start = (state_q == S_DECIDE) && !stat.first && !chain_err_q && !too_long;
		cmd.issue = (state_q == S_ISSUE) && !phase_q;
		cmd.upc = upc_q;
		cmd.commit = (state_q == S_COMMIT);
		cmd.emit = emit_go;
		cmd.chain_err = chain_err_q;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid)
					state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (cmd.start)
					state_d = S_ISSUE;
				else
					state_d = stat.last ? S_EMIT : S_IDLE;
			end
			S_ISSUE: begin
				if (phase_q && upc_q == UPC_W'(NUM_UOPS - 1))
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!stat.busy)
					state_d = S_COMMIT;
			end
			S_COMMIT: begin
				state_d = stat.last ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (emit_go)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			upc_q <= '0;
			phase_q <= 1'b0;
			chain_err_q <= 1'b0;
			chain_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// chain state
			if (cmd.seed) begin
				chain_err_q <= 1'b0;
				chain_cnt_q <= '0;
			end else if (state_q == S_DECIDE && !chain_err_q && too_long) begin
				chain_err_q <= 1'b1;
			end else if (cmd.start) begin
				chain_cnt_q <= idx[CNT_W-1:0];
			end else if (cmd.commit && stat.bad) begin
				chain_err_q <= 1'b1;
			end
			// micro-op counter; issue on phase zero, advance on phase one
			if (cmd.start) begin
				upc_q <= '0;
				phase_q <= 1'b0;
			end else if (state_q == S_ISSUE) begin
				phase_q <= !phase_q;
				if (phase_q)
					upc_q <= upc_q + UPC_W'(1);
			end
			// output register valid
			if (emit_go)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

### hdl/tpc_dp.sv
// Datapath: record registers, shared rounding multiplier pipeline, accumulators, output register.
module tpc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [tpc_pkg::IN_TDATA_W-1:0]      s_tdata,  // trans_x,y,z, quat_w,x,y,z, scale_x,y,z
	input  logic                                s_tuser,  // first_record
	input  logic                                s_tlast,  // last_record
	output logic [tpc_pkg::OUT_TDATA_W-1:0]     m_tdata,  // world_x,y,z, rot_w,x,y,z
	output logic                                m_tuser,  // pose_ok
	input  tpc_pkg::tpc_cmd_t                   cmd,
	output tpc_pkg::tpc_stat_t                  stat
);
	import tpc_pkg::*;

	localparam logic signed [ACC_W+1:0] BIG = 66'sd1 <<< 62;
	localparam logic [PROD_W-1:0] RND16 = PROD_W'(1) << 15;
	localparam logic [PROD_W-1:0] RND30 = PROD_W'(1) << 29;

	// record and architectural state
	logic signed [POS_W-1:0] rec_t_q [3];
	logic signed [Q_W-1:0]   rec_q_q [4];
	logic signed [S_W-1:0]   rec_s_q [3];
	logic                    rec_first_q, rec_last_q;
	logic signed [POS_W-1:0] pos_q [3];
	logic signed [POS_W-1:0] held_q [3];
	logic signed [Q_W-1:0]   rot_q [4];
	logic signed [ACC_W-1:0] p_q [3];
	logic signed [ACC_W-1:0] uv_q [3];
	logic signed [ACC_W-1:0] uuv_q [3];
	logic signed [ACC_W-1:0] nr_q [4];
	logic                    ovf_q;

	// multiplier pipeline
	uop_t                    op;
	logic signed [ACC_W-1:0] a_val, a_abs;
	logic signed [Q_W-1:0]   b_val;
	logic signed [Q_W:0]     b_ext, b_abs;
	logic [MAG_W-1:0]        ma_s1;
	logic [Q_W-1:0]          mb_s1;
	logic                    neg_s1, sh16_s1, clr_s1;
	dst_t                    dst_s1;
	logic                    m1_v, m2_v, r_v, a_v;
	logic [Q_W-1:0]          mul_a;
	logic [2*Q_W-1:0]        mul_p;
	logic [2*Q_W-1:0]        pl_s2;
	logic [MAG_W-1:0]        ph_s3;
	logic                    neg_s3, sh16_s3, clr_s3;
	dst_t                    dst_s3;
	logic [PROD_W-1:0]       prod, rsum, mag_full;
	logic [MAG_W-1:0]        mag_s4;
	logic                    movf_s4, neg_s4, clr_s4;
	dst_t                    dst_s4;
	logic signed [ACC_W-1:0] base;
	logic signed [ACC_W+1:0] sum;
	logic                    sum_ovf;

	// commit and emit
	logic                    fit_bad;
	logic                    ok;
	logic signed [POS_W-1:0] wsel [3];
	logic signed [Q_W-1:0]   rsel [4];
	logic [OUT_TDATA_W-1:0]  out_data_q;
	logic                    out_ok_q;

	assign op = uop_rom(cmd.upc);

	// operand A select
	always_comb begin
		unique case (op.a)
			A_POS0: a_val = ACC_W'(pos_q[0]);
			A_POS1: a_val = ACC_W'(pos_q[1]);
			A_POS2: a_val = ACC_W'(pos_q[2]);
			A_P0:   a_val = p_q[0];
			A_P1:   a_val = p_q[1];
			A_P2:   a_val = p_q[2];
			A_UV0:  a_val = uv_q[0];
			A_UV1:  a_val = uv_q[1];
			A_UV2:  a_val = uv_q[2];
			A_UUV0: a_val = uuv_q[0];
			A_UUV1: a_val = uuv_q[1];
			A_UUV2: a_val = uuv_q[2];
			A_T0:   a_val = ACC_W'(rec_t_q[0]);
			A_T1:   a_val = ACC_W'(rec_t_q[1]);
			A_T2:   a_val = ACC_W'(rec_t_q[2]);
			A_QW:   a_val = ACC_W'(rec_q_q[0]);
			A_QX:   a_val = ACC_W'(rec_q_q[1]);
			A_QY:   a_val = ACC_W'(rec_q_q[2]);
			A_QZ:   a_val = ACC_W'(rec_q_q[3]);
			default: a_val = '0;
		endcase
	end

	// operand B select
	always_comb begin
		unique case (op.b)
			B_S0:  b_val = rec_s_q[0];
			B_S1:  b_val = rec_s_q[1];
			B_S2:  b_val = rec_s_q[2];
			B_QW:  b_val = rec_q_q[0];
			B_QX:  b_val = rec_q_q[1];
			B_QY:  b_val = rec_q_q[2];
			B_QZ:  b_val = rec_q_q[3];
			B_RW:  b_val = rot_q[0];
			B_RX:  b_val = rot_q[1];
			B_RY:  b_val = rot_q[2];
			B_RZ:  b_val = rot_q[3];
			B_ONE: b_val = Q_ONE;
			default: b_val = '0;
		endcase
	end

	assign a_abs = a_val[ACC_W-1] ? -a_val : a_val;
	assign b_ext = (Q_W+1)'(b_val);
	assign b_abs = b_val[Q_W-1] ? -b_ext : b_ext;

	// one 32x32 multiplier: low half of |a| first, then high half
	assign mul_a = m1_v ? ma_s1[Q_W-1:0] : Q_W'(ma_s1[MAG_W-1:Q_W]);
	assign mul_p = mul_a * mb_s1;

	// combine halves, round half away from zero, drop fraction bits
	assign prod = {ph_s3, 32'b0} + PROD_W'(pl_s2);
	assign rsum = prod + (sh16_s3 ? RND16 : RND30);
	assign mag_full = sh16_s3 ? (rsum >> 16) : (rsum >> 30);

	// accumulate with range check
	always_comb begin
		unique case (dst_s4)
			D_P0:   base = p_q[0];
			D_P1:   base = p_q[1];
			D_P2:   base = p_q[2];
			D_UV0:  base = uv_q[0];
			D_UV1:  base = uv_q[1];
			D_UV2:  base = uv_q[2];
			D_UUV0: base = uuv_q[0];
			D_UUV1: base = uuv_q[1];
			D_UUV2: base = uuv_q[2];
			D_NR0:  base = nr_q[0];
			D_NR1:  base = nr_q[1];
			D_NR2:  base = nr_q[2];
			D_NR3:  base = nr_q[3];
			default: base = '0;
		endcase
		if (clr_s4)
			base = '0;
	end

	assign sum = neg_s4 ? ((ACC_W+2)'(base) - $signed((ACC_W+2)'(mag_s4)))
	                    : ((ACC_W+2)'(base) + $signed((ACC_W+2)'(mag_s4)));
	assign sum_ovf = (sum >= BIG) || (sum <= -BIG);

	// range of the new pose before commit
	always_comb begin
		fit_bad = 1'b0;
		for (int i = 0; i < 3; i++)
			if (uuv_q[i][ACC_W-1:POS_W-1] != '0 && uuv_q[i][ACC_W-1:POS_W-1] != '1)
				fit_bad = 1'b1;
		for (int i = 0; i < 4; i++)
			if (nr_q[i][ACC_W-1:Q_W-1] != '0 && nr_q[i][ACC_W-1:Q_W-1] != '1)
				fit_bad = 1'b1;
	end

	// pose check and output selection
	always_comb begin
		ok = !cmd.chain_err;
		for (int i = 0; i < 3; i++) begin
			if (pos_q[i] > POS_LIMIT || pos_q[i] < -POS_LIMIT)
				ok = 1'b0;
		end
		for (int i = 0; i < 3; i++)
			wsel[i] = ok ? pos_q[i] : held_q[i];
		rsel[0] = ok ? rot_q[0] : Q_ONE;
		for (int i = 1; i < 4; i++)
			rsel[i] = ok ? rot_q[i] : '0;
	end

	assign stat.first = rec_first_q;
	assign stat.last = rec_last_q;
	assign stat.busy = m1_v | m2_v | r_v | a_v;
	assign stat.bad = ovf_q | fit_bad;

	assign m_tdata = out_data_q;
	assign m_tuser = out_ok_q;

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m1_v <= 1'b0;
			m2_v <= 1'b0;
			r_v <= 1'b0;
			a_v <= 1'b0;
		end else begin
			m1_v <= cmd.issue;
			m2_v <= m1_v;
			r_v <= m2_v;
			a_v <= r_v;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			ma_s1 <= a_abs[MAG_W-1:0];
			mb_s1 <= b_abs[Q_W-1:0];
			neg_s1 <= a_val[ACC_W-1] ^ b_val[Q_W-1] ^ op.sub;
			sh16_s1 <= op.sh16;
			clr_s1 <= op.clr;
			dst_s1 <= op.dst;
		end
		if (m1_v)
			pl_s2 <= mul_p;
		if (m2_v) begin
			ph_s3 <= mul_p[MAG_W-1:0];
			neg_s3 <= neg_s1;
			sh16_s3 <= sh16_s1;
			clr_s3 <= clr_s1;
			dst_s3 <= dst_s1;
		end
		if (r_v) begin
			mag_s4 <= mag_full[MAG_W-1:0];
			movf_s4 <= |mag_full[PROD_W-1:MAG_W];
			neg_s4 <= neg_s3;
			clr_s4 <= clr_s3;
			dst_s4 <= dst_s3;
		end
	end

	// record capture, scratch accumulators and output payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 3; i++) begin
				rec_t_q[i] <= s_tdata[i*POS_W +: POS_W];
				rec_s_q[i] <= s_tdata[3*POS_W + 4*Q_W + i*S_W +: S_W];
			end
			for (int i = 0; i < 4; i++)
				rec_q_q[i] <= s_tdata[3*POS_W + i*Q_W +: Q_W];
			rec_first_q <= s_tuser;
			rec_last_q <= s_tlast;
		end
		if (a_v) begin
			unique case (dst_s4)
				D_P0:   p_q[0] <= sum[ACC_W-1:0];
				D_P1:   p_q[1] <= sum[ACC_W-1:0];
				D_P2:   p_q[2] <= sum[ACC_W-1:0];
				D_UV0:  uv_q[0] <= sum[ACC_W-1:0];
				D_UV1:  uv_q[1] <= sum[ACC_W-1:0];
				D_UV2:  uv_q[2] <= sum[ACC_W-1:0];
				D_UUV0: uuv_q[0] <= sum[ACC_W-1:0];
				D_UUV1: uuv_q[1] <= sum[ACC_W-1:0];
				D_UUV2: uuv_q[2] <= sum[ACC_W-1:0];
				D_NR0:  nr_q[0] <= sum[ACC_W-1:0];
				D_NR1:  nr_q[1] <= sum[ACC_W-1:0];
				D_NR2:  nr_q[2] <= sum[ACC_W-1:0];
				D_NR3:  nr_q[3] <= sum[ACC_W-1:0];
				default: ;
			endcase
		end
		if (cmd.emit) begin
			for (int i = 0; i < 3; i++)
				out_data_q[i*POS_W +: POS_W] <= wsel[i];
			for (int i = 0; i < 4; i++)
				out_data_q[3*POS_W + i*Q_W +: Q_W] <= rsel[i];
			out_ok_q <= ok;
		end
	end

	// accumulated pose, held position and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				held_q[i] <= '0;
			end
			rot_q[0] <= Q_ONE;
			for (int i = 1; i < 4; i++)
				rot_q[i] <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.seed) begin
				for (int i = 0; i < 3; i++)
					pos_q[i] <= rec_t_q[i];
				for (int i = 0; i < 4; i++)
					rot_q[i] <= rec_q_q[i];
			end else if (cmd.commit && !(ovf_q || fit_bad)) begin
				for (int i = 0; i < 3; i++)
					pos_q[i] <= uuv_q[i][POS_W-1:0];
				for (int i = 0; i < 4; i++)
					rot_q[i] <= nr_q[i][Q_W-1:0];
			end
			if (cmd.emit && ok) begin
				for (int i = 0; i < 3; i++)
					held_q[i] <= pos_q[i];
			end
			if (cmd.start)
				ovf_q <= 1'b0;
			else if (a_v && (movf_s4 || sum_ovf))
				ovf_q <= 1'b1;
		end
	end

endmodule

### hdl/tpc_checker.sv
// Port checker for the pose composer and its bind.
`include "trs_hierarchy_pose_compose_macros.svh"

module tpc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [tpc_pkg::OUT_TDATA_W-1:0] m_tdata,  // world_x,y,z, rot_w,x,y,z
	input logic                            m_tuser   // pose_ok
);
	import tpc_pkg::*;

	`TPC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`TPC_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
	`TPC_ASSERT_IMP(a_bad_identity, m_tvalid && !m_tuser, m_tdata[175:144] == Q_ONE && m_tdata[271:176] == '0, "bad pose without identity rotation")
	`TPC_ASSERT_NXT(a_one_record, s_tvalid && s_tready, !s_tready, "record taken in back-to-back cycles")

endmodule

bind trs_hierarchy_pose_compose tpc_checker u_tpc_checker (.*);
